// ----- sv/hmr_pkg.sv -----
// Shared constants and types of the HID message reassembler.
package hmr_pkg;

  // Packet and message geometry.
  localparam int INIT_DATA_BYTES   = 57;
  localparam int CONT_DATA_BYTES   = 59;
  localparam int MAX_MESSAGE_BYTES = 7609;

  // Data words per packet and bytes per word.
  localparam int NUM_WORDS  = 8;
  localparam int WORD_BYTES = 8;

  // Widths that follow from the geometry.
  localparam int LEN_W  = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int SIZE_W = $clog2(NUM_WORDS * WORD_BYTES + 1);
  localparam int REM_W  = $clog2(CONT_DATA_BYTES);
  localparam int SEQ_W  = 8;
  localparam int IDX_W  = $clog2(NUM_WORDS);

  // Packet kinds.
  localparam logic OP_INIT = 1'b0;
  localparam logic OP_CONT = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_ACCEPTED       = 3'd0,
    ST_TOO_LARGE      = 3'd1,
    ST_WRONG_CHANNEL  = 3'd2,
    ST_WRONG_SEQUENCE = 3'd3,
    ST_NOTHING_OWED   = 3'd4
  } status_t;

endpackage

// ----- sv/hmr_pkt_if.sv -----
// Packet channel: valid, ready and the fields of one U2FHID packet.
interface hmr_pkt_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] channel_id;
  logic [7:0]  command_or_sequence;
  logic [15:0] byte_count;
  logic [63:0] data_0;
  logic [63:0] data_1;
  logic [63:0] data_2;
  logic [63:0] data_3;
  logic [63:0] data_4;
  logic [63:0] data_5;
  logic [63:0] data_6;
  logic [63:0] data_7;

  modport source (
    output valid, operation, channel_id, command_or_sequence, byte_count,
           data_0, data_1, data_2, data_3, data_4, data_5, data_6, data_7,
    input  ready
  );

  modport sink (
    input  valid, operation, channel_id, command_or_sequence, byte_count,
           data_0, data_1, data_2, data_3, data_4, data_5, data_6, data_7,
    output ready
  );
endinterface

// ----- sv/hmr_chunk_if.sv -----
// Chunk channel: valid, ready and the fields of one reassembled chunk.
interface hmr_chunk_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] message_channel;
  logic [7:0]  message_command;
  logic [12:0] message_length;
  logic [63:0] chunk_data;
  logic [3:0]  chunk_bytes;
  logic [12:0] chunk_offset;
  logic        last_of_packet;
  logic        message_complete;

  modport source (
    output valid, status, message_channel, message_command, message_length,
           chunk_data, chunk_bytes, chunk_offset, last_of_packet,
           message_complete,
    input  ready
  );

  modport sink (
    input  valid, status, message_channel, message_command, message_length,
           chunk_data, chunk_bytes, chunk_offset, last_of_packet,
           message_complete,
    output ready
  );
endinterface

// ----- sv/hid_message_reassembler.sv -----
// U2FHID message reassembler: checks packets and emits accepted bytes as chunks.
//
// Each packet transfer on pkt yields one or more chunk transfers on chunk: an
// accepted packet gives one chunk per eight accepted bytes (the last one
// partial), an empty init gives a single empty chunk, and a rejected packet
// gives one chunk that carries only its status. The chunk emitter produces
// one chunk per cycle from its registered copy of the packet while the chunk
// channel is not stalled; a packet gives at most eight chunks, and that
// emitter sets the sustained rate. A one-packet input register lets the next
// packet be checked and loaded in the cycle the previous packet's last chunk
// leaves the emitter, so packets follow each other with no gap. A packet
// passes through the input register, the emitter and the output register in
// turn. Message state is updated when the packet is checked, so later packets
// always see the state left by earlier ones.
module hid_message_reassembler
  import hmr_pkg::*;
(
  input logic          clk,
  input logic          rst,
  hmr_pkt_if.sink      pkt,
  hmr_chunk_if.source  chunk
);

  // Input register.
  logic              hold_valid;
  logic              hold_op;
  logic [31:0]       hold_chan;
  logic [7:0]        hold_cs;
  logic [15:0]       hold_bcnt;
  logic [63:0]       hold_data [NUM_WORDS];

  // Message state.
  logic              message_open;
  logic [31:0]       open_channel;
  logic [7:0]        open_command;
  logic [LEN_W-1:0]  total_length;
  logic [LEN_W-1:0]  bytes_received;
  logic [SEQ_W-1:0]  expect_seq;
  logic [REM_W-1:0]  seq_rem;

  // Next message state, valid when a packet is taken.
  logic              message_open_next;
  logic [31:0]       open_channel_next;
  logic [7:0]        open_command_next;
  logic [LEN_W-1:0]  total_length_next;
  logic [LEN_W-1:0]  bytes_received_next;
  logic [SEQ_W-1:0]  expect_seq_next;
  logic [REM_W-1:0]  seq_rem_next;

  // Chunk emitter.
  logic              emit_busy;
  logic [IDX_W-1:0]  emit_idx;
  logic [SIZE_W-1:0] emit_size;
  logic [LEN_W-1:0]  emit_base;
  status_t           emit_status;
  logic [63:0]       emit_words [NUM_WORDS];
  logic [31:0]       emit_chan;
  logic [7:0]        emit_cmd;
  logic [LEN_W-1:0]  emit_len;
  logic              emit_complete;

  // Decision for the held packet.
  status_t           dec_status;
  logic [SIZE_W-1:0] dec_size;
  logic [LEN_W-1:0]  dec_base;
  logic [SIZE_W-1:0] init_size;
  logic [SIZE_W-1:0] cont_size;
  logic [LEN_W-1:0]  owed;
  logic [SIZE_W:0]   rem_sum;
  logic              rem_wrap;
  logic              chan_ok;

  // Emitter step signals.
  logic              out_adv;
  logic              step;
  logic              step_last;
  logic [SIZE_W-1:0] remain;
  logic [3:0]        step_bytes;
  logic [63:0]       step_word;
  logic [63:0]       step_data;
  logic              take;

  // Handshake between the input register and the emitter.
  assign out_adv   = !chunk.valid || chunk.ready;
  assign step      = emit_busy && out_adv;
  assign remain    = emit_size - SIZE_W'({emit_idx, 3'b000});
  assign step_last = remain <= SIZE_W'(WORD_BYTES);
  assign take      = hold_valid && (!emit_busy || (step && step_last));
  assign pkt.ready = !hold_valid || take;

  // Input register load.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (pkt.ready) begin
      hold_valid <= pkt.valid;
    end
    if (pkt.valid && pkt.ready) begin
      hold_op      <= pkt.operation;
      hold_chan    <= pkt.channel_id;
      hold_cs      <= pkt.command_or_sequence;
      hold_bcnt    <= pkt.byte_count;
      hold_data[0] <= pkt.data_0;
      hold_data[1] <= pkt.data_1;
      hold_data[2] <= pkt.data_2;
      hold_data[3] <= pkt.data_3;
      hold_data[4] <= pkt.data_4;
      hold_data[5] <= pkt.data_5;
      hold_data[6] <= pkt.data_6;
      hold_data[7] <= pkt.data_7;
    end
  end

  // Sizes and sequence bookkeeping for the held packet.
  assign init_size = (hold_bcnt > 16'(INIT_DATA_BYTES)) ? SIZE_W'(INIT_DATA_BYTES)
                                                         : SIZE_W'(hold_bcnt);
  assign owed      = (total_length > bytes_received) ? total_length - bytes_received
                                                      : '0;
  assign cont_size = (owed > LEN_W'(CONT_DATA_BYTES)) ? SIZE_W'(CONT_DATA_BYTES)
                                                       : SIZE_W'(owed);
  assign rem_sum   = (SIZE_W + 1)'(seq_rem) + (SIZE_W + 1)'(cont_size);
  assign rem_wrap  = rem_sum >= (SIZE_W + 1)'(CONT_DATA_BYTES);
  assign chan_ok   = message_open && (hold_chan == open_channel);

  // Packet check and next message state.
  always_comb begin
    dec_status          = ST_ACCEPTED;
    dec_size            = '0;
    dec_base            = '0;
    message_open_next   = message_open;
    open_channel_next   = open_channel;
    open_command_next   = open_command;
    total_length_next   = total_length;
    bytes_received_next = bytes_received;
    expect_seq_next     = expect_seq;
    seq_rem_next        = seq_rem;
    if (hold_op == OP_INIT) begin
      if (hold_bcnt > 16'(MAX_MESSAGE_BYTES)) begin
        dec_status = ST_TOO_LARGE;
      end else begin
        // A new message replaces the one in progress.
        dec_size            = init_size;
        message_open_next   = 1'b1;
        open_channel_next   = hold_chan;
        open_command_next   = hold_cs;
        total_length_next   = LEN_W'(hold_bcnt);
        bytes_received_next = LEN_W'(init_size);
        expect_seq_next     = '0;
        seq_rem_next        = '0;
      end
    end else if (!chan_ok) begin
      dec_status = ST_WRONG_CHANNEL;
    end else if (expect_seq != hold_cs) begin
      dec_status = ST_WRONG_SEQUENCE;
    end else if (cont_size == '0) begin
      dec_status = ST_NOTHING_OWED;
    end else begin
      // Continuation bytes land at the current fill level.
      dec_size            = cont_size;
      dec_base            = bytes_received;
      bytes_received_next = bytes_received + LEN_W'(cont_size);
      if (rem_wrap) begin
        expect_seq_next = expect_seq + SEQ_W'(1);
        seq_rem_next    = REM_W'(rem_sum - (SIZE_W + 1)'(CONT_DATA_BYTES));
      end else begin
        seq_rem_next    = REM_W'(rem_sum);
      end
    end
  end

  // Message state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      message_open   <= 1'b0;
      open_channel   <= '0;
      open_command   <= '0;
      total_length   <= '0;
      bytes_received <= '0;
      expect_seq     <= '0;
      seq_rem        <= '0;
    end else if (take) begin
      message_open   <= message_open_next;
      open_channel   <= open_channel_next;
      open_command   <= open_command_next;
      total_length   <= total_length_next;
      bytes_received <= bytes_received_next;
      expect_seq     <= expect_seq_next;
      seq_rem        <= seq_rem_next;
    end
  end

  // Emitter control: load on take, advance one chunk per output transfer slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_busy <= 1'b0;
      emit_idx  <= '0;
    end else if (take) begin
      emit_busy <= 1'b1;
      emit_idx  <= '0;
    end else if (step && step_last) begin
      emit_busy <= 1'b0;
    end else if (step) begin
      emit_idx  <= emit_idx + IDX_W'(1);
    end
  end

  // Emitter payload: a copy of the packet data and the message snapshot.
  always_ff @(posedge clk) begin
    if (take) begin
      emit_size     <= dec_size;
      emit_base     <= dec_base;
      emit_status   <= dec_status;
      emit_chan     <= open_channel_next;
      emit_cmd      <= open_command_next;
      emit_len      <= total_length_next;
      emit_complete <= message_open_next && (bytes_received_next == total_length_next);
      for (int i = 0; i < NUM_WORDS; i++) begin
        emit_words[i] <= hold_data[i];
      end
    end
  end

  // Current chunk: pick the word and clear bytes past the packet's end.
  assign step_bytes = step_last ? remain[3:0] : 4'(WORD_BYTES);
  assign step_word  = emit_words[emit_idx];
  always_comb begin
    for (int b = 0; b < WORD_BYTES; b++) begin
      step_data[8*b +: 8] = (4'(b) < step_bytes) ? step_word[8*b +: 8] : 8'h00;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk.valid <= 1'b0;
    end else if (out_adv) begin
      chunk.valid <= emit_busy;
    end
    if (step) begin
      chunk.status           <= emit_status;
      chunk.message_channel  <= emit_chan;
      chunk.message_command  <= emit_cmd;
      chunk.message_length   <= emit_len;
      chunk.chunk_data       <= step_data;
      chunk.chunk_bytes      <= step_bytes;
      chunk.chunk_offset     <= emit_base + LEN_W'({emit_idx, 3'b000});
      chunk.last_of_packet   <= step_last;
      chunk.message_complete <= emit_complete;
    end
  end

endmodule

// ----- sv/hmr_checker.sv -----
// Port-level checks of the reassembler's chunk stream, bound to the top level.
module hmr_chunk_checks
  import hmr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        chunk_valid,
  input logic        chunk_ready,
  input logic [2:0]  status,
  input logic [63:0] chunk_data,
  input logic [3:0]  chunk_bytes,
  input logic [12:0] chunk_offset,
  input logic        last_of_packet
);

  // A stalled chunk keeps its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    chunk_valid && !chunk_ready |=>
      chunk_valid && $stable(chunk_data) && $stable(chunk_offset) &&
      $stable(chunk_bytes))
    else $error("stalled chunk changed");

  // A rejection is a single empty chunk at offset zero.
  a_reject_empty: assert property (@(posedge clk) disable iff (rst)
    chunk_valid && (status != ST_ACCEPTED) |->
      last_of_packet && (chunk_bytes == 4'd0) && (chunk_offset == '0) &&
      (chunk_data == '0))
    else $error("rejection chunk is not empty");

  // Only the last chunk of a packet may be short.
  a_full_chunks: assert property (@(posedge clk) disable iff (rst)
    chunk_valid && !last_of_packet |-> chunk_bytes == 4'(WORD_BYTES))
    else $error("short chunk before the end of a packet");

  // The next chunk of a packet follows at once, eight bytes further on.
  a_next_offset: assert property (@(posedge clk) disable iff (rst)
    chunk_valid && chunk_ready && !last_of_packet |=>
      chunk_valid && (status == ST_ACCEPTED) &&
      (chunk_offset == $past(chunk_offset) + 13'(WORD_BYTES)))
    else $error("chunk sequence broken");

endmodule

bind hid_message_reassembler hmr_chunk_checks u_hmr_checker (
  .clk            (clk),
  .rst            (rst),
  .chunk_valid    (chunk.valid),
  .chunk_ready    (chunk.ready),
  .status         (chunk.status),
  .chunk_data     (chunk.chunk_data),
  .chunk_bytes    (chunk.chunk_bytes),
  .chunk_offset   (chunk.chunk_offset),
  .last_of_packet (chunk.last_of_packet)
);
